// ===== rtl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and fixed field widths for the table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int PC_WIDTH  = 9;
    localparam int IDX_WIDTH = 8;

    typedef enum logic [2:0] {
        RD_FIRST = 3'd0,
        RD_LAST  = 3'd1,
        RD_SCAN  = 3'd2,
        RD_I1    = 3'd3,
        RD_I2    = 3'd4
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_HOLD   = 3'd0,
        RES_MEM    = 3'd1,
        RES_A      = 3'd2,
        RES_ERR    = 3'd3,
        RES_INTERP = 3'd4
    } t_res_sel;

    typedef struct packed {
        logic     knot_wr;
        logic     query_ld;
        t_rd_sel  rd_sel;
        logic     scan_init;
        logic     scan_adv;
        logic     scan_step;
        logic     hold_a;
        logic     setup;
        logic     mul_step;
        logic     div_step;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic t_le_x;
        logic t_ge_x;
        logic x_gt_t;
        logic x2_gt_x1;
        logic idx_same;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/table_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator_top
// Knot load: requests are taken back to back while no query is in progress.
// Query at or below the first knot is clamped to that knot's value in S_LAST;
// at or above the last knot, it is clamped to the last knot's value in S_CHKLAST.
// Interpolated query: a knot scan up to the first knot above the query,
// followed by the serial multiply and then the serial divide.
// One query at a time; reset clears control and sets point_count to 1,
// the knot tables are not cleared.
// ----------------------------------------------------------------------------
module table_linear_interpolator_top #(
    parameter int MAX_POINTS  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // knot_index, knot_x, knot_f, query_value, zero pad
    input  logic [((tli_pkg::IDX_WIDTH + 3 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // action
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // result_value, zero pad
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // status
    output logic                          o_m_axis_tuser,
    input  logic                          i_cfg_wr_en,
    input  logic [tli_pkg::PC_WIDTH-1:0]  i_cfg_wr_data
);

    localparam int VW    = VALUE_WIDTH;
    localparam int IW    = tli_pkg::IDX_WIDTH;
    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;

    tli_pkg::t_dp_cmd  cmd;
    tli_pkg::t_dp_stat stat;

    logic [IW-1:0] knot_index;
    logic [VW-1:0] knot_x;
    logic [VW-1:0] knot_f;
    logic [VW-1:0] query_value;
    logic [VW-1:0] result_value;

    assign knot_index  = i_s_axis_tdata[IW-1:0];
    assign knot_x      = i_s_axis_tdata[IW +: VW];
    assign knot_f      = i_s_axis_tdata[IW + VW +: VW];
    assign query_value = i_s_axis_tdata[IW + 2 * VW +: VW];

    assign o_m_axis_tdata = OUT_W'(result_value);

    tli_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_action   (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tli_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_knot_index   (knot_index),
        .i_knot_x       (knot_x),
        .i_knot_f       (knot_f),
        .i_query_value  (query_value),
        .i_m_tready     (i_m_axis_tready),
        .o_m_tvalid     (o_m_axis_tvalid),
        .o_result_value (result_value),
        .o_status       (o_m_axis_tuser)
    );

endmodule

// ===== rtl/tli_dp.sv =====
// ----------------------------------------------------------------------------
// tli_dp
// Knot memories, search registers, serial multiply/divide and output stage.
// ----------------------------------------------------------------------------
module tli_dp #(
    parameter int MAX_POINTS  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tli_pkg::t_dp_cmd             i_cmd,
    output tli_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_wr_en,
    input  logic [tli_pkg::PC_WIDTH-1:0] i_cfg_wr_data,
    input  logic [tli_pkg::IDX_WIDTH-1:0] i_knot_index,
    input  logic [VALUE_WIDTH-1:0]       i_knot_x,
    input  logic [VALUE_WIDTH-1:0]       i_knot_f,
    input  logic [VALUE_WIDTH-1:0]       i_query_value,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [VALUE_WIDTH-1:0]       o_result_value,
    output logic                         o_status
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    logic [VW-1:0] r_x_mem [MAX_POINTS];
    logic [VW-1:0] r_f_mem [MAX_POINTS];

    logic [tli_pkg::PC_WIDTH-1:0] r_point_count;
    logic [VW-1:0] r_t;
    logic [AW-1:0] r_last;
    logic [AW-1:0] r_scan_addr;
    logic [AW-1:0] r_rd_idx;
    logic [VW-1:0] r_rd_x;
    logic [VW-1:0] r_rd_f;
    logic          r_e_found;
    logic [AW-1:0] r_e_idx;
    logic          r_prev_eq;
    logic [AW-1:0] r_i1;
    logic [AW-1:0] r_i2;
    logic [VW-1:0] r_x1;
    logic [VW-1:0] r_fa;
    logic [VW-1:0] r_den;
    logic [VW-1:0] r_mag;
    logic          r_neg;
    logic [VW-1:0] r_hi;
    logic [VW-1:0] r_lo;
    logic [VW-1:0] r_res;
    logic          r_status;
    logic          r_out_valid;
    logic [VW-1:0] r_out_data;
    logic          r_out_user;

    logic [AW-1:0] last_idx;
    logic          idx_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic signed [VW-1:0] t_s;
    logic signed [VW-1:0] x_s;
    logic signed [VW-1:0] x1_s;
    logic          t_eq_x;
    logic [AW-1:0] idx_m1;
    logic signed [VW:0] f_diff;
    logic [VW:0]   mul_sum;
    logic [VW:0]   div_sh;
    logic [VW:0]   div_dif;
    logic          div_ge;

    always_comb begin
        if (r_point_count == '0) begin
            last_idx = '0;
        end else if (32'(r_point_count) > MAX_POINTS) begin
            last_idx = AW'(MAX_POINTS - 1);
        end else begin
            last_idx = AW'(32'(r_point_count) - 32'd1);
        end
    end

    assign idx_ok  = 32'(i_knot_index) < MAX_POINTS;
    assign wr_addr = AW'(i_knot_index);

    always_comb begin
        case (i_cmd.rd_sel)
            tli_pkg::RD_FIRST: rd_addr = '0;
            tli_pkg::RD_LAST:  rd_addr = r_last;
            tli_pkg::RD_SCAN:  rd_addr = r_scan_addr;
            tli_pkg::RD_I1:    rd_addr = r_i1;
            tli_pkg::RD_I2:    rd_addr = r_i2;
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.knot_wr && idx_ok) begin
            r_x_mem[wr_addr] <= i_knot_x;
            r_f_mem[wr_addr] <= i_knot_f;
        end
        r_rd_x   <= r_x_mem[rd_addr];
        r_rd_f   <= r_f_mem[rd_addr];
        r_rd_idx <= rd_addr;
    end

    assign t_s    = r_t;
    assign x_s    = r_rd_x;
    assign x1_s   = r_x1;
    assign t_eq_x = (r_t == r_rd_x);
    assign idx_m1 = r_rd_idx - AW'(1);

    assign f_diff  = $signed({r_rd_f[VW-1], r_rd_f}) - $signed({r_fa[VW-1], r_fa});
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : '0);
    assign div_sh  = {r_hi, r_lo[VW-1]};
    assign div_ge  = div_sh >= {1'b0, r_den};
    assign div_dif = div_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= tli_pkg::PC_WIDTH'(1);
        end else if (i_cfg_wr_en) begin
            r_point_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_ld) begin
            r_t    <= i_query_value;
            r_last <= last_idx;
        end
        if (i_cmd.scan_init) begin
            r_scan_addr <= AW'(1);
            r_e_found   <= 1'b0;
            r_prev_eq   <= 1'b0;
        end else if (i_cmd.scan_adv) begin
            r_scan_addr <= r_scan_addr + AW'(1);
        end
        if (i_cmd.scan_step) begin
            if (x_s > t_s) begin
                r_i1 <= r_e_found ? r_e_idx : idx_m1;
                r_i2 <= r_prev_eq ? idx_m1 : r_rd_idx;
            end else begin
                if (t_eq_x && !r_e_found) begin
                    r_e_found <= 1'b1;
                    r_e_idx   <= r_rd_idx;
                end
                r_prev_eq <= t_eq_x;
            end
        end
        if (i_cmd.hold_a) begin
            r_x1 <= r_rd_x;
            r_fa <= r_rd_f;
        end
        if (i_cmd.setup) begin
            r_den <= r_rd_x - r_x1;
            r_neg <= f_diff[VW];
            r_mag <= f_diff[VW] ? VW'(-f_diff) : VW'(f_diff);
            r_hi  <= '0;
            r_lo  <= r_t - r_x1;
        end else if (i_cmd.mul_step) begin
            r_hi <= mul_sum[VW:1];
            r_lo <= {mul_sum[0], r_lo[VW-1:1]};
        end else if (i_cmd.div_step) begin
            r_hi <= div_ge ? div_dif[VW-1:0] : div_sh[VW-1:0];
            r_lo <= {r_lo[VW-2:0], div_ge};
        end
        case (i_cmd.res_sel)
            tli_pkg::RES_HOLD: ;
            tli_pkg::RES_MEM: begin
                r_res    <= r_rd_f;
                r_status <= 1'b0;
            end
            tli_pkg::RES_A: begin
                r_res    <= r_fa;
                r_status <= 1'b0;
            end
            tli_pkg::RES_ERR: begin
                r_res    <= '0;
                r_status <= 1'b1;
            end
            tli_pkg::RES_INTERP: begin
                r_res    <= r_neg ? (r_fa - r_lo) : (r_fa + r_lo);
                r_status <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
            r_out_user <= r_status;
        end
    end

    assign o_stat.t_le_x   = t_s <= x_s;
    assign o_stat.t_ge_x   = t_s >= x_s;
    assign o_stat.x_gt_t   = x_s > t_s;
    assign o_stat.x2_gt_x1 = x_s > x1_s;
    assign o_stat.idx_same = (r_i1 == r_i2);
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid     = r_out_valid;
    assign o_result_value = r_out_data;
    assign o_status       = r_out_user;

endmodule

// ===== rtl/tli_ctrl.sv =====
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for knot loads, clamp checks, scan and serial arithmetic.
// ----------------------------------------------------------------------------
module tli_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_action,
    output logic               o_s_tready,
    input  tli_pkg::t_dp_stat  i_stat,
    output tli_pkg::t_dp_cmd   o_cmd
);

    localparam int SW = $clog2(VALUE_WIDTH);
    localparam logic [SW-1:0] STEP_LAST = SW'(VALUE_WIDTH - 1);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_FIRST   = 12'b0000_0000_0010,
        S_LAST    = 12'b0000_0000_0100,
        S_CHKLAST = 12'b0000_0000_1000,
        S_SCAN    = 12'b0000_0001_0000,
        S_RD1     = 12'b0000_0010_0000,
        S_RD2     = 12'b0000_0100_0000,
        S_SETUP   = 12'b0000_1000_0000,
        S_MUL     = 12'b0001_0000_0000,
        S_DIV     = 12'b0010_0000_0000,
        S_FIN     = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [SW-1:0] r_step;
    logic [SW-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_action) begin
                        o_cmd.query_ld = 1'b1;
                        n_state        = S_FIRST;
                    end else begin
                        o_cmd.knot_wr = 1'b1;
                    end
                end
            end
            S_FIRST: begin
                o_cmd.rd_sel    = tli_pkg::RD_FIRST;
                o_cmd.scan_init = 1'b1;
                n_state         = S_LAST;
            end
            S_LAST: begin
                o_cmd.rd_sel = tli_pkg::RD_LAST;
                if (i_stat.t_le_x) begin
                    o_cmd.res_sel = tli_pkg::RES_MEM;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_CHKLAST;
                end
            end
            S_CHKLAST: begin
                o_cmd.rd_sel   = tli_pkg::RD_SCAN;
                o_cmd.scan_adv = 1'b1;
                if (i_stat.t_ge_x) begin
                    o_cmd.res_sel = tli_pkg::RES_MEM;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_sel    = tli_pkg::RD_SCAN;
                o_cmd.scan_adv  = 1'b1;
                o_cmd.scan_step = 1'b1;
                if (i_stat.x_gt_t) begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd_sel = tli_pkg::RD_I1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_sel = tli_pkg::RD_I2;
                o_cmd.hold_a = 1'b1;
                n_state      = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_step      = STEP_LAST;
                if (i_stat.x2_gt_x1) begin
                    n_state = S_MUL;
                end else if (i_stat.idx_same) begin
                    o_cmd.res_sel = tli_pkg::RES_A;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.res_sel = tli_pkg::RES_ERR;
                    n_state       = S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == '0) begin
                    n_step  = STEP_LAST;
                    n_state = S_DIV;
                end else begin
                    n_step = r_step - SW'(1);
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step - SW'(1);
                end
            end
            S_FIN: begin
                o_cmd.res_sel = tli_pkg::RES_INTERP;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
